// ----- rtl/poly_voice_allocator_adsr_core_macros.svh -----
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shorthand for the clocked, reset-qualified assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_ADSR_CORE_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_ADSR_CORE_MACROS_SVH

// same-cycle implication
`define PVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ----- rtl/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, codes and constants of the voice allocator and ADSR core.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int VOICES_DEF = 8;
    localparam int REPORT_MAX = 8;

    localparam logic [16:0] FULL_SCALE  = 17'd65536;
    localparam logic [16:0] ATTACK_DONE = 17'd65471;
    localparam logic [16:0] NEAR_EPS    = 17'd6;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [1:0] VS_IDLE     = 2'd0;
    localparam logic [1:0] VS_ACTIVE   = 2'd1;
    localparam logic [1:0] VS_RELEASED = 2'd2;

    localparam logic [2:0] EG_IDLE    = 3'd0;
    localparam logic [2:0] EG_ATTACK  = 3'd1;
    localparam logic [2:0] EG_DECAY   = 3'd2;
    localparam logic [2:0] EG_SUSTAIN = 3'd3;
    localparam logic [2:0] EG_RELEASE = 3'd4;

    localparam logic [1:0] CFG_ATTACK  = 2'd0;
    localparam logic [1:0] CFG_DECAY   = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;
    localparam logic [1:0] CFG_SUSTAIN = 2'd3;

    localparam logic [16:0] ATTACK_RST  = 17'd68;
    localparam logic [16:0] DECAY_RST   = 17'd8;
    localparam logic [16:0] RELEASE_RST = 17'd5;
    localparam logic [16:0] SUSTAIN_RST = 17'd49152;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_in;

    typedef struct packed {
        logic [2:0]  voice_index;
        logic [16:0] level;
        logic [6:0]  voice_note;
        logic [6:0]  voice_velocity;
        logic        sounding;
        logic        stolen;
        logic [3:0]  released_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  stage;
        logic [16:0] level;
        logic [6:0]  note;
        logic        note_valid;
        logic [6:0]  velocity;
        logic [31:0] age;
    } t_voice;

    typedef struct packed {
        logic [16:0] attack_inc;
        logic [16:0] decay_dec;
        logic [16:0] release_dec;
        logic [16:0] sustain_lvl;
    } t_cfg;

endpackage

// ----- rtl/pva_env_unit.sv -----
// ----------------------------------------------------------------------------
// Envelope step unit
// Advances one voice by one tick through attack, decay, sustain and release.
// ----------------------------------------------------------------------------
module pva_env_unit (
    input  pva_pkg::t_voice i_voice,
    input  pva_pkg::t_cfg   i_cfg,
    output pva_pkg::t_voice o_voice,
    output logic            o_sounding
);
    import pva_pkg::*;

    logic [16:0] atk_st;
    logic [16:0] dec_st;
    logic [16:0] rel_st;
    logic [17:0] sus;
    logic [17:0] lvl;
    logic [17:0] sum;
    logic [17:0] diff;
    logic [16:0] nl;
    logic        adv;

    function automatic logic [16:0] clamp_step(input logic [16:0] s);
        logic [16:0] r;
        if (s == 17'd0) begin
            r = 17'd1;
        end else if (s > FULL_SCALE) begin
            r = FULL_SCALE;
        end else begin
            r = s;
        end
        return r;
    endfunction

    assign atk_st = clamp_step(i_cfg.attack_inc);
    assign dec_st = clamp_step(i_cfg.decay_dec);
    assign rel_st = clamp_step(i_cfg.release_dec);
    assign sus    = {1'b0, (i_cfg.sustain_lvl > FULL_SCALE) ? FULL_SCALE
                                                          : i_cfg.sustain_lvl};
    assign lvl    = {1'b0, i_voice.level};
    assign adv    = i_voice.note_valid &&
                    !(i_voice.status == VS_IDLE && i_voice.stage == EG_IDLE);

    always_comb begin
        o_voice = i_voice;
        nl      = 17'd0;
        sum     = 18'd0;
        diff    = 18'd0;
        if (adv) begin
            unique case (i_voice.stage)
                EG_ATTACK: begin
                    sum = lvl + {1'b0, atk_st};
                    nl  = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[16:0];
                    if (nl >= ATTACK_DONE) begin
                        o_voice.stage = EG_DECAY;
                    end
                end
                EG_DECAY: begin
                    diff = lvl - {1'b0, dec_st};
                    nl   = (lvl >= {1'b0, dec_st} && diff > sus) ? diff[16:0] : sus[16:0];
                    if ({1'b0, nl} <= sus + {1'b0, NEAR_EPS}) begin
                        o_voice.stage = EG_SUSTAIN;
                    end
                end
                EG_SUSTAIN: begin
                    nl = sus[16:0];
                end
                EG_RELEASE: begin
                    diff = lvl - {1'b0, rel_st};
                    nl   = (lvl > {1'b0, rel_st}) ? diff[16:0] : 17'd0;
                    if (nl <= NEAR_EPS) begin
                        nl                 = 17'd0;
                        o_voice.stage      = EG_IDLE;
                        o_voice.status     = VS_IDLE;
                        o_voice.note_valid = 1'b0;
                    end
                end
                default: begin
                    nl = 17'd0;
                end
            endcase
            o_voice.level = nl;
        end
    end

    assign o_sounding = adv && !(o_voice.status == VS_IDLE && o_voice.level == 17'd0);

endmodule

// ----- rtl/pva_voice_tbl.sv -----
// ----------------------------------------------------------------------------
// Voice table
// Per-voice state in flip-flops, one scan read port and one write port.
// ----------------------------------------------------------------------------
module pva_voice_tbl #(
    parameter int VOICES = pva_pkg::VOICES_DEF,
    parameter int IW     = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [IW-1:0]   i_rd_idx,
    output pva_pkg::t_voice o_rd_voice,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_idx,
    input  pva_pkg::t_voice i_wr_voice
);
    import pva_pkg::*;

    t_voice r_voice [VOICES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_voice[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_voice[i_wr_idx] <= i_wr_voice;
        end
    end

    assign o_rd_voice = r_voice[i_rd_idx];

endmodule

// ----- rtl/poly_voice_allocator_adsr_core.sv -----
// ----------------------------------------------------------------------------
// Polyphonic voice allocator with ADSR envelopes
// Allocates voices on note on, releases them on note off and steps every
// voice envelope on a sample tick, one voice a cycle unless a result stalls.
// ----------------------------------------------------------------------------
// A note on scans every voice, then writes the chosen one; a note off scans
// every voice, then reports; a tick steps every voice. The single table read
// port and single envelope step unit visit one voice per cycle, but a final
// write or report, and a tick report, wait while the result side stalls. The
// input is stalled while an item is being worked on; a finished result waits
// in the output register while the next item is taken. A tick reports up to
// the first eight voices, one beat each, with last on the final one.
module poly_voice_allocator_adsr_core #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  pva_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output pva_pkg::t_out o_out_data,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [16:0]  i_cfg_data
);
    import pva_pkg::*;

    localparam int IW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW      = $clog2(VOICES + 1);
    localparam int NREP    = (VOICES < REPORT_MAX) ? VOICES : REPORT_MAX;
    localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);
    localparam logic [IW-1:0] LAST_REP = IW'(NREP - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ON_SCAN  = 3'd1;
    localparam logic [2:0] S_ON_WRITE = 3'd2;
    localparam logic [2:0] S_OFF_SCAN = 3'd3;
    localparam logic [2:0] S_OFF_DONE = 3'd4;
    localparam logic [2:0] S_TICK     = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    t_in           r_req;
    t_cfg          r_cfg;
    logic [31:0]   r_gen, n_gen;
    logic          r_idle_found, n_idle_found;
    logic [IW-1:0] r_idle_idx, n_idle_idx;
    logic          r_rel_found, n_rel_found;
    logic [IW-1:0] r_rel_idx, n_rel_idx;
    logic [31:0]   r_rel_age, n_rel_age;
    logic [IW-1:0] r_all_idx, n_all_idx;
    logic [31:0]   r_all_age, n_all_age;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid;
    t_out          r_out, n_out;

    t_voice        rd_voice;
    t_voice        env_voice;
    logic          env_sounding;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    t_voice        wr_voice;
    logic          out_load;
    logic          out_free;
    logic          accept;
    logic          last_idx;
    logic          emit;

    pva_voice_tbl #(
        .VOICES (VOICES),
        .IW     (IW)
    ) u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_rd_voice (rd_voice),
        .i_wr_en    (wr_en),
        .i_wr_idx   (wr_idx),
        .i_wr_voice (wr_voice)
    );

    pva_env_unit u_env (
        .i_voice    (rd_voice),
        .i_cfg      (r_cfg),
        .o_voice    (env_voice),
        .o_sounding (env_sounding)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign last_idx    = (r_idx == LAST_IDX);
    assign emit        = (32'(r_idx) < NREP);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_gen        = r_gen;
        n_idle_found = r_idle_found;
        n_idle_idx   = r_idle_idx;
        n_rel_found  = r_rel_found;
        n_rel_idx    = r_rel_idx;
        n_rel_age    = r_rel_age;
        n_all_idx    = r_all_idx;
        n_all_age    = r_all_age;
        n_cnt        = r_cnt;
        n_out        = r_out;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        wr_idx       = r_idx;
        wr_voice     = rd_voice;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx        = '0;
                    n_idle_found = 1'b0;
                    n_rel_found  = 1'b0;
                    n_cnt        = '0;
                    unique case (i_in_data.operation)
                        OP_NOTE_ON:  n_state = S_ON_SCAN;
                        OP_NOTE_OFF: n_state = S_OFF_SCAN;
                        OP_TICK:     n_state = S_TICK;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ON_SCAN: begin
                if (rd_voice.status == VS_IDLE && !r_idle_found) begin
                    n_idle_found = 1'b1;
                    n_idle_idx   = r_idx;
                end
                if (rd_voice.status == VS_RELEASED &&
                    (!r_rel_found || rd_voice.age < r_rel_age)) begin
                    n_rel_found = 1'b1;
                    n_rel_idx   = r_idx;
                    n_rel_age   = rd_voice.age;
                end
                // ties keep the lower index
                if (r_idx == '0 || rd_voice.age < r_all_age) begin
                    n_all_idx = r_idx;
                    n_all_age = rd_voice.age;
                end
                if (last_idx) begin
                    n_state = S_ON_WRITE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ON_WRITE: begin
                if (out_free) begin
                    priority if (r_idle_found) begin
                        wr_idx = r_idle_idx;
                    end else if (r_rel_found) begin
                        wr_idx = r_rel_idx;
                    end else begin
                        wr_idx = r_all_idx;
                    end
                    n_gen               = r_gen + 32'd1;
                    wr_en               = 1'b1;
                    wr_voice.status     = VS_ACTIVE;
                    wr_voice.stage      = EG_ATTACK;
                    wr_voice.level      = 17'd0;
                    wr_voice.note       = r_req.note;
                    wr_voice.note_valid = 1'b1;
                    wr_voice.velocity   = r_req.velocity;
                    wr_voice.age        = n_gen;
                    n_out                = '0;
                    n_out.voice_index    = 3'(wr_idx);
                    n_out.voice_note     = r_req.note;
                    n_out.voice_velocity = r_req.velocity;
                    n_out.stolen         = !r_idle_found;
                    n_out.last           = 1'b1;
                    out_load             = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_OFF_SCAN: begin
                if (rd_voice.status == VS_ACTIVE && rd_voice.note_valid &&
                    rd_voice.note == r_req.note) begin
                    wr_en          = 1'b1;
                    wr_voice.status = VS_RELEASED;
                    wr_voice.stage  = EG_RELEASE;
                    n_cnt           = r_cnt + 1'b1;
                end
                if (last_idx) begin
                    n_state = S_OFF_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_OFF_DONE: begin
                if (out_free) begin
                    n_out                = '0;
                    n_out.released_count = (32'(r_cnt) > 32'd15) ? 4'd15 : 4'(r_cnt);
                    n_out.last           = 1'b1;
                    out_load             = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            S_TICK: begin
                // voices beyond the report window advance without a beat
                if (!emit || out_free) begin
                    wr_en    = 1'b1;
                    wr_voice = env_voice;
                    if (emit) begin
                        n_out                = '0;
                        n_out.voice_index    = 3'(r_idx);
                        n_out.level          = env_voice.level;
                        n_out.voice_note     = env_voice.note_valid ? env_voice.note : 7'd0;
                        n_out.voice_velocity = env_voice.note_valid ? env_voice.velocity
                                                                    : 7'd0;
                        n_out.sounding       = env_sounding;
                        n_out.last           = (r_idx == LAST_REP);
                        out_load             = 1'b1;
                    end
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_gen        <= 32'd0;
            r_idle_found <= 1'b0;
            r_rel_found  <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_gen        <= n_gen;
            r_idle_found <= n_idle_found;
            r_rel_found  <= n_rel_found;
            r_cnt        <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idle_idx <= n_idle_idx;
        r_rel_idx  <= n_rel_idx;
        r_rel_age  <= n_rel_age;
        r_all_idx  <= n_all_idx;
        r_all_age  <= n_all_age;
        r_out      <= n_out;
        if (accept) begin
            r_req <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_inc  <= ATTACK_RST;
            r_cfg.decay_dec   <= DECAY_RST;
            r_cfg.release_dec <= RELEASE_RST;
            r_cfg.sustain_lvl <= SUSTAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATTACK:  r_cfg.attack_inc  <= i_cfg_data;
                CFG_DECAY:   r_cfg.decay_dec   <= i_cfg_data;
                CFG_RELEASE: r_cfg.release_dec <= i_cfg_data;
                CFG_SUSTAIN: r_cfg.sustain_lvl <= i_cfg_data;
                default:     r_cfg             <= r_cfg;
            endcase
        end
    end

endmodule

// ----- rtl/pva_chk.sv -----
// ----------------------------------------------------------------------------
// Voice allocator port checker
// Watches the ports of the voice allocator core and flags illegal beats.
// ----------------------------------------------------------------------------
`include "poly_voice_allocator_adsr_core_macros.svh"

module pva_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input pva_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pva_pkg::t_out o_out_data
);
    import pva_pkg::*;

    // a stalled result beat holds
    `PVA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // a real operation keeps the input stalled while it runs
    `PVA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_data.operation == OP_NOTE_ON || i_in_data.operation == OP_NOTE_OFF || i_in_data.operation == OP_TICK), o_in_stall)

    // a steal only comes from a note on: single beat at level zero
    `PVA_ASSERT_NOW(a_stolen, i_clk, i_rst_n, o_out_valid && o_out_data.stolen, o_out_data.last && !o_out_data.sounding && o_out_data.level == 17'd0)

    // a note off beat carries nothing but its count and last
    `PVA_ASSERT_NOW(a_release, i_clk, i_rst_n, o_out_valid && o_out_data.released_count != 4'd0, o_out_data.last && o_out_data.voice_index == 3'd0 && o_out_data.level == 17'd0 && !o_out_data.sounding)

endmodule

bind poly_voice_allocator_adsr_core pva_chk u_pva_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- test/poly_voice_allocator_adsr_core_checker.sv -----
// ----------------------------------------------------------------------------
// Voice allocator result checker
// Watches the item, result and register ports of the voice allocator, keeps
// its own voice table and envelope settings, works out the beats each
// accepted item must produce and compares every result beat against them.
// ----------------------------------------------------------------------------
module poly_voice_allocator_adsr_core_checker #(
    parameter int VOICES = pva_pkg::VOICES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  pva_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  pva_pkg::t_out i_out_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [16:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);

    import pva_pkg::*;

    localparam int REPORTS = (VOICES < REPORT_MAX) ? VOICES : REPORT_MAX;

    t_voice      voice_tab [VOICES];
    t_cfg        env_cfg;
    logic [31:0] gen_count;
    t_out        reports_due [$];
    int          fail_count = 0;

    function automatic logic [31:0] step_of(logic [16:0] s);
        if (s == 17'd0) return 32'd1;
        return (s > FULL_SCALE) ? 32'(FULL_SCALE) : 32'(s);
    endfunction

    function automatic void step_envelope(int v);
        logic [31:0] lvl;
        logic [31:0] sus;
        logic [31:0] st;
        lvl = 32'(voice_tab[v].level);
        sus = (env_cfg.sustain_lvl > FULL_SCALE) ? 32'(FULL_SCALE)
                                                 : 32'(env_cfg.sustain_lvl);
        case (voice_tab[v].stage)
            EG_ATTACK: begin
                st  = step_of(env_cfg.attack_inc);
                lvl = (lvl + st > 32'(FULL_SCALE)) ? 32'(FULL_SCALE) : lvl + st;
                if (lvl >= 32'(ATTACK_DONE)) voice_tab[v].stage = EG_DECAY;
            end
            EG_DECAY: begin
                st  = step_of(env_cfg.decay_dec);
                lvl = (lvl >= st && lvl - st > sus) ? lvl - st : sus;
                if (lvl <= sus + 32'(NEAR_EPS)) voice_tab[v].stage = EG_SUSTAIN;
            end
            EG_SUSTAIN: begin
                lvl = sus;
            end
            EG_RELEASE: begin
                st  = step_of(env_cfg.release_dec);
                lvl = (lvl > st) ? lvl - st : 32'd0;
                // finished: free the voice and forget its note
                if (lvl <= 32'(NEAR_EPS)) begin
                    lvl = 32'd0;
                    voice_tab[v].stage      = EG_IDLE;
                    voice_tab[v].status     = VS_IDLE;
                    voice_tab[v].note_valid = 1'b0;
                end
            end
            default: begin
                lvl = 32'd0;
            end
        endcase
        voice_tab[v].level = lvl[16:0];
    endfunction

    // lowest idle voice, else oldest released, else oldest overall
    function automatic int pick_voice();
        int i;
        int best;
        best = -1;
        for (i = 0; i < VOICES; i++)
            if (voice_tab[i].status == VS_IDLE) return i;
        for (i = 0; i < VOICES; i++)
            if (voice_tab[i].status == VS_RELEASED &&
                (best < 0 || voice_tab[i].age < voice_tab[best].age)) best = i;
        if (best >= 0) return best;
        best = 0;
        for (i = 1; i < VOICES; i++)
            if (voice_tab[i].age < voice_tab[best].age) best = i;
        return best;
    endfunction

    function automatic void predict_item(t_in item);
        int   v;
        int   i;
        int   released;
        logic snd;
        t_out rpt;
        rpt = '0;
        case (item.operation)
            OP_NOTE_ON: begin
                v = pick_voice();
                rpt.stolen = (voice_tab[v].status != VS_IDLE);
                voice_tab[v].status     = VS_ACTIVE;
                voice_tab[v].stage      = EG_ATTACK;
                voice_tab[v].note       = item.note;
                voice_tab[v].note_valid = 1'b1;
                voice_tab[v].velocity   = item.velocity;
                voice_tab[v].level      = '0;
                gen_count = gen_count + 32'd1;
                voice_tab[v].age = gen_count;
                rpt.voice_index    = 3'(v);
                rpt.voice_note     = item.note;
                rpt.voice_velocity = item.velocity;
                rpt.last           = 1'b1;
                reports_due.insert(reports_due.size(), rpt);
            end
            OP_NOTE_OFF: begin
                released = 0;
                for (i = 0; i < VOICES; i++) begin
                    if (voice_tab[i].status == VS_ACTIVE && voice_tab[i].note_valid &&
                        voice_tab[i].note == item.note) begin
                        voice_tab[i].status = VS_RELEASED;
                        voice_tab[i].stage  = EG_RELEASE;
                        released++;
                    end
                end
                rpt.released_count = (released > 15) ? 4'd15 : 4'(released);
                rpt.last           = 1'b1;
                reports_due.insert(reports_due.size(), rpt);
            end
            OP_TICK: begin
                for (i = 0; i < VOICES; i++) begin
                    snd = 1'b0;
                    if (voice_tab[i].note_valid &&
                        !(voice_tab[i].status == VS_IDLE && voice_tab[i].stage == EG_IDLE)) begin
                        step_envelope(i);
                        snd = !(voice_tab[i].status == VS_IDLE &&
                                voice_tab[i].level == 17'd0);
                    end
                    if (i < REPORTS) begin
                        rpt = '0;
                        rpt.voice_index    = 3'(i);
                        rpt.level          = voice_tab[i].level;
                        rpt.voice_note     = voice_tab[i].note_valid ? voice_tab[i].note
                                                                     : 7'd0;
                        rpt.voice_velocity = voice_tab[i].note_valid ? voice_tab[i].velocity
                                                                     : 7'd0;
                        rpt.sounding       = snd;
                        rpt.last           = (i == REPORTS - 1);
                        reports_due.insert(reports_due.size(), rpt);
                    end
                end
            end
            default: ;  // unused code: no beat
        endcase
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out due;
        int   i;
        if (!i_rst_n) begin
            for (i = 0; i < VOICES; i++) voice_tab[i] = '0;
            env_cfg.attack_inc  = ATTACK_RST;
            env_cfg.decay_dec   = DECAY_RST;
            env_cfg.release_dec = RELEASE_RST;
            env_cfg.sustain_lvl = SUSTAIN_RST;
            gen_count = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ATTACK:  env_cfg.attack_inc  = i_cfg_data;
                    CFG_DECAY:   env_cfg.decay_dec   = i_cfg_data;
                    CFG_RELEASE: env_cfg.release_dec = i_cfg_data;
                    CFG_SUSTAIN: env_cfg.sustain_lvl = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, actual %h",
                             $time, i_out_data);
                    fail_count++;
                end else begin
                    due = reports_due.pop_front();
                    check_field("voice_index", 32'(due.voice_index),
                                32'(i_out_data.voice_index));
                    check_field("level", 32'(due.level), 32'(i_out_data.level));
                    check_field("voice_note", 32'(due.voice_note),
                                32'(i_out_data.voice_note));
                    check_field("voice_velocity", 32'(due.voice_velocity),
                                32'(i_out_data.voice_velocity));
                    check_field("sounding", 32'(due.sounding), 32'(i_out_data.sounding));
                    check_field("stolen", 32'(due.stolen), 32'(i_out_data.stolen));
                    check_field("released_count", 32'(due.released_count),
                                32'(i_out_data.released_count));
                    check_field("last", 32'(due.last), 32'(i_out_data.last));
                end
            end
            if (i_in_valid && !i_in_stall) predict_item(i_in_data);
        end
        o_pending    = reports_due.size();
        o_fail_count = fail_count;
    end

endmodule

// ----- test/poly_voice_allocator_adsr_core_tb.sv -----
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note on, note off and tick beats into the voice allocator through
// a directed opening and several random phases with different envelope
// settings and idle patterns; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module poly_voice_allocator_adsr_core_tb;

    import pva_pkg::*;

    localparam int         VOICES    = VOICES_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [16:0] cfg_data;
    int          fail_count;
    int          pending;
    logic        in_taken = 1'b0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    poly_voice_allocator_adsr_core #(
        .VOICES(VOICES)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    poly_voice_allocator_adsr_core_checker #(
        .VOICES(VOICES)
    ) envelope_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // capture the input handshake before the edge updates the block
    always @(posedge clk) in_taken <= in_valid && !in_stall;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_beat(input logic [1:0] op, input logic [6:0] nt,
                             input logic [6:0] vel);
        // idle the sender cycle by cycle before offering the beat
        if ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{operation: op, note: nt, velocity: vel};
        do @(negedge clk); while (!in_taken);
    endtask

    // hold off until every beat is out and the voice walk has settled
    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
        repeat (2 * VOICES + 4) @(negedge clk);
    endtask

    task automatic load_envelope(input logic [16:0] atk, input logic [16:0] dcy,
                                 input logic [16:0] rel, input logic [16:0] sus);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ATTACK;
        cfg_data <= atk;
        @(negedge clk);
        cfg_idx  <= CFG_DECAY;
        cfg_data <= dcy;
        @(negedge clk);
        cfg_idx  <= CFG_RELEASE;
        cfg_data <= rel;
        @(negedge clk);
        cfg_idx  <= CFG_SUSTAIN;
        cfg_data <= sus;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_beats(input int count);
        int         sent;
        int         pick;
        logic [6:0] nt;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            // mostly a small set of notes so note off finds its voices
            nt = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                             : 7'(48 + 2 * $urandom_range(0, 4));
            if (pick < 35) begin
                send_beat(OP_NOTE_ON, nt, 7'($urandom));
                sent++;
            end else if (pick < 60) begin
                send_beat(OP_NOTE_OFF, nt, 7'($urandom));
                sent++;
            end else if (pick < 95) begin
                send_beat(OP_TICK, 7'($urandom), 7'($urandom));
                sent++;
            end else begin
                send_beat(OP_UNUSED, 7'($urandom), 7'($urandom));
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic run_phase(input int gap, input int stall, input logic [16:0] atk,
                             input logic [16:0] dcy, input logic [16:0] rel,
                             input logic [16:0] sus, input int count);
        wait_drained();
        load_envelope(atk, dcy, rel, sus);
        gap_pct   = gap;
        stall_pct = stall;
        random_beats(count);
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        out_stall = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_ATTACK;
        cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, release, ignored code, both kinds of steal
        send_beat(OP_NOTE_ON, 7'd0, 7'd0);
        send_beat(OP_NOTE_ON, 7'd127, 7'd127);
        send_beat(OP_TICK, 7'd0, 7'd0);
        send_beat(OP_NOTE_OFF, 7'd127, 7'd0);
        send_beat(OP_NOTE_OFF, 7'd55, 7'd0);
        send_beat(OP_UNUSED, 7'd127, 7'd127);
        send_beat(OP_TICK, 7'd127, 7'd127);
        send_beat(OP_NOTE_ON, 7'd60, 7'd10);
        send_beat(OP_NOTE_ON, 7'd61, 7'd20);
        send_beat(OP_NOTE_ON, 7'd62, 7'd30);
        send_beat(OP_NOTE_ON, 7'd60, 7'd40);
        send_beat(OP_NOTE_ON, 7'd63, 7'd50);
        send_beat(OP_NOTE_ON, 7'd64, 7'd60);
        send_beat(OP_NOTE_ON, 7'd65, 7'd70);
        send_beat(OP_NOTE_ON, 7'd70, 7'd1);
        send_beat(OP_NOTE_OFF, 7'd60, 7'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        in_valid <= 1'b0;
        wait_drained();

        // one-tick envelopes walk every stage quickly
        load_envelope(17'd65536, 17'd65536, 17'd65536, 17'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        send_beat(OP_NOTE_OFF, 7'd61, 7'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        send_beat(OP_TICK, 7'd0, 7'd0);
        in_valid <= 1'b0;

        // out-of-range registers: zero steps act as one, sustain clamps
        run_phase(0, 0, 17'h1FFFF, 17'd0, 17'd0, 17'h1FFFF, 25);
        run_phase(87, 0, 17'd40000, 17'd65536, 17'd30000, 17'd20000, 25);
        run_phase(0, 87, 17'($urandom_range(8000, 65536)), 17'($urandom_range(2000, 40000)),
                  17'($urandom_range(2000, 40000)), 17'($urandom_range(0, 65536)), 25);
        run_phase(22, 22, 17'($urandom_range(8000, 65536)), 17'($urandom_range(2000, 40000)),
                  17'($urandom_range(2000, 40000)), 17'($urandom_range(0, 65536)), 25);

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
